// ----- hw/rtl/tfn_pkg.sv -----
// Shared constants, types and latency functions for the triangle face normal unit.
// No dependencies.
package tfn_pkg;

   localparam int UNIT_FRAC   = 30;   // fraction bits of the unit edge vectors
   localparam int SCALED_W    = 31;   // magnitude width after scaling to [2^30, 2^31)
   localparam int SCALE_TOP   = 30;   // target position of the leading one
   localparam int SUM_W       = 64;   // sum of three squares
   localparam int LEN_W       = 32;   // floor(sqrt(sum))
   localparam int SQRT_STEPS  = 32;
   localparam int REM_W       = 36;   // square root partial remainder
   localparam int DREM_W      = 33;   // divider partial remainder
   localparam int NORMAL_W    = 16;   // width of a normal component on the port
   localparam int CROSS_W     = 64;   // cross product component, Q4.60 signed
   localparam int NORM_FIXED  = 41;   // normalizer latency minus its fraction bits
   localparam int CROSS_LAT   = 2;

   typedef struct packed {
      logic valid;
      logic zero;
   } norm_stat_type;

   function automatic int norm_latency(input int frac);
      return frac + NORM_FIXED;
   endfunction

   function automatic int top_latency(input int normal_frac);
      return 1 + norm_latency(UNIT_FRAC) + CROSS_LAT + norm_latency(normal_frac) + 1;
   endfunction

endpackage

// ----- hw/rtl/tfn_norm.sv -----
// Pipelined vector normalizer: abs, leading-one scale, sum of squares,
// 32-stage square root and one-bit-per-stage dividers. Uses tfn_pkg.
module tfn_norm
   import tfn_pkg::*;
#(
   parameter int IN_W = 33,
   parameter int FRAC = 30
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   input  logic signed [IN_W-1:0]   in_c [3],
   output norm_stat_type            out_stat,
   output logic signed [FRAC+1:0]   out_q [3]
);

   localparam int PW = $clog2(IN_W);
   localparam int NW = SCALED_W + FRAC + 1;
   localparam int DS = FRAC + 1;   // divider steps = quotient bits

   // front stages
   logic             s1_vld_ff, s2_vld_ff, s3_vld_ff, s4_vld_ff, s5_vld_ff;
   logic [IN_W-1:0]  s1_mag_ff [3];
   logic [IN_W-1:0]  s2_mag_ff [3];
   logic [IN_W-1:0]  s3_mag_ff [3];
   logic [2:0]       s1_neg_ff, s2_neg_ff, s3_neg_ff, s4_neg_ff, s5_neg_ff;
   logic [IN_W-1:0]  s2_or_ff;
   logic             s2_zero_ff, s3_zero_ff, s4_zero_ff, s5_zero_ff;
   logic [PW-1:0]    s3_p_ff;
   logic [PW-1:0]    p_in;
   logic [SCALED_W-1:0] s4_a_ff [3];
   logic [SCALED_W-1:0] s5_a_ff [3];
   logic [2*SCALED_W-1:0] s5_sq_ff [3];
   logic [63:0]      shift_tmp [3];

   // square root stages, index 0 holds the sum
   logic               rt_vld_ff  [SQRT_STEPS+1];
   logic [LEN_W-1:0]   rt_root_ff [SQRT_STEPS+1];
   logic [REM_W-1:0]   rt_rem_ff  [SQRT_STEPS+1];
   logic [SUM_W-1:0]   rt_x_ff    [SQRT_STEPS+1];
   logic [SCALED_W-1:0] rt_a_ff   [SQRT_STEPS+1][3];
   logic [2:0]         rt_neg_ff  [SQRT_STEPS+1];
   logic               rt_zero_ff [SQRT_STEPS+1];

   // divider stages, index 0 holds the rounded numerator
   logic               dv_vld_ff  [DS+1];
   logic [LEN_W-1:0]   dv_len_ff  [DS+1];
   logic [DREM_W-1:0]  dv_rem_ff  [DS+1][3];
   logic [FRAC:0]      dv_low_ff  [DS+1][3];
   logic [FRAC:0]      dv_q_ff    [DS+1][3];
   logic [2:0]         dv_neg_ff  [DS+1];
   logic               dv_zero_ff [DS+1];
   logic [NW-1:0]      numer [3];

   logic               out_vld_ff, out_zero_ff;
   logic signed [FRAC+1:0] out_q_ff [3];

   // valid chain
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
         s4_vld_ff <= 1'b0;
         s5_vld_ff <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= in_valid;
         s2_vld_ff <= s1_vld_ff;
         s3_vld_ff <= s2_vld_ff;
         s4_vld_ff <= s3_vld_ff;
         s5_vld_ff <= s4_vld_ff;
         out_vld_ff <= dv_vld_ff[DS];
      end
   end

   always_comb begin
      p_in = '0;
      for (int b = 0; b < IN_W; b++) begin
         if (s2_or_ff[b]) p_in = PW'(b);
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (int'(s3_p_ff) >= SCALE_TOP)
            shift_tmp[i] = 64'(s3_mag_ff[i]) >> (int'(s3_p_ff) - SCALE_TOP);
         else
            shift_tmp[i] = 64'(s3_mag_ff[i]) << (SCALE_TOP - int'(s3_p_ff));
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         s1_mag_ff[i] <= in_c[i][IN_W-1] ? IN_W'(-in_c[i]) : IN_W'(in_c[i]);
         s1_neg_ff[i] <= in_c[i][IN_W-1];
         s2_mag_ff[i] <= s1_mag_ff[i];
         s3_mag_ff[i] <= s2_mag_ff[i];
         s4_a_ff[i]   <= shift_tmp[i][SCALED_W-1:0];
         s5_a_ff[i]   <= s4_a_ff[i];
         s5_sq_ff[i]  <= s4_a_ff[i] * s4_a_ff[i];
      end
      s2_or_ff   <= s1_mag_ff[0] | s1_mag_ff[1] | s1_mag_ff[2];
      s2_zero_ff <= ~|(s1_mag_ff[0] | s1_mag_ff[1] | s1_mag_ff[2]);
      s2_neg_ff  <= s1_neg_ff;
      s3_p_ff    <= p_in;
      s3_neg_ff  <= s2_neg_ff;
      s3_zero_ff <= s2_zero_ff;
      s4_neg_ff  <= s3_neg_ff;
      s4_zero_ff <= s3_zero_ff;
      s5_neg_ff  <= s4_neg_ff;
      s5_zero_ff <= s4_zero_ff;
   end

   // sum of squares enters the root pipeline
   always_ff @(posedge clock) begin
      if (reset) rt_vld_ff[0] <= 1'b0;
      else       rt_vld_ff[0] <= s5_vld_ff;
   end

   always_ff @(posedge clock) begin
      rt_root_ff[0] <= '0;
      rt_rem_ff[0]  <= '0;
      rt_x_ff[0]    <= SUM_W'(s5_sq_ff[0]) + SUM_W'(s5_sq_ff[1]) + SUM_W'(s5_sq_ff[2]);
      for (int i = 0; i < 3; i++) rt_a_ff[0][i] <= s5_a_ff[i];
      rt_neg_ff[0]  <= s5_neg_ff;
      rt_zero_ff[0] <= s5_zero_ff;
   end

   for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
      logic [REM_W-1:0] rem_sh, trial;
      logic             ge;

      assign rem_sh = {rt_rem_ff[k][REM_W-3:0], rt_x_ff[k][SUM_W-1 -: 2]};
      assign trial  = {{(REM_W-LEN_W-2){1'b0}}, rt_root_ff[k], 2'b01};
      assign ge     = rem_sh >= trial;

      always_ff @(posedge clock) begin
         if (reset) rt_vld_ff[k+1] <= 1'b0;
         else       rt_vld_ff[k+1] <= rt_vld_ff[k];
      end

      always_ff @(posedge clock) begin
         rt_rem_ff[k+1]  <= ge ? rem_sh - trial : rem_sh;
         rt_root_ff[k+1] <= {rt_root_ff[k][LEN_W-2:0], ge};
         rt_x_ff[k+1]    <= rt_x_ff[k] << 2;
         for (int i = 0; i < 3; i++) rt_a_ff[k+1][i] <= rt_a_ff[k][i];
         rt_neg_ff[k+1]  <= rt_neg_ff[k];
         rt_zero_ff[k+1] <= rt_zero_ff[k];
      end
   end

   // rounded numerator: a * 2^FRAC + len/2
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         numer[i] = (NW'(rt_a_ff[SQRT_STEPS][i]) << FRAC)
                  + NW'(rt_root_ff[SQRT_STEPS] >> 1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) dv_vld_ff[0] <= 1'b0;
      else       dv_vld_ff[0] <= rt_vld_ff[SQRT_STEPS];
   end

   always_ff @(posedge clock) begin
      dv_len_ff[0] <= rt_root_ff[SQRT_STEPS];
      for (int i = 0; i < 3; i++) begin
         dv_rem_ff[0][i] <= DREM_W'(numer[i] >> DS);
         dv_low_ff[0][i] <= numer[i][FRAC:0];
         dv_q_ff[0][i]   <= '0;
      end
      dv_neg_ff[0]  <= rt_neg_ff[SQRT_STEPS];
      dv_zero_ff[0] <= rt_zero_ff[SQRT_STEPS];
   end

   for (genvar j = 0; j < DS; j++) begin : g_div
      logic [DREM_W-1:0] sh [3];
      logic [2:0]        ge;

      always_comb begin
         for (int i = 0; i < 3; i++) begin
            sh[i] = {dv_rem_ff[j][i][DREM_W-2:0], dv_low_ff[j][i][FRAC]};
            ge[i] = sh[i] >= DREM_W'(dv_len_ff[j]);
         end
      end

      always_ff @(posedge clock) begin
         if (reset) dv_vld_ff[j+1] <= 1'b0;
         else       dv_vld_ff[j+1] <= dv_vld_ff[j];
      end

      always_ff @(posedge clock) begin
         dv_len_ff[j+1] <= dv_len_ff[j];
         for (int i = 0; i < 3; i++) begin
            dv_rem_ff[j+1][i] <= ge[i] ? sh[i] - DREM_W'(dv_len_ff[j]) : sh[i];
            dv_low_ff[j+1][i] <= dv_low_ff[j][i] << 1;
            dv_q_ff[j+1][i]   <= {dv_q_ff[j][i][FRAC-1:0], ge[i]};
         end
         dv_neg_ff[j+1]  <= dv_neg_ff[j];
         dv_zero_ff[j+1] <= dv_zero_ff[j];
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         out_q_ff[i] <= dv_neg_ff[DS][i] ? -$signed({1'b0, dv_q_ff[DS][i]})
                                         :  $signed({1'b0, dv_q_ff[DS][i]});
      end
      out_zero_ff <= dv_zero_ff[DS];
   end

   assign out_stat.valid = out_vld_ff;
   assign out_stat.zero  = out_zero_ff;
   assign out_q          = out_q_ff;

endmodule

// ----- hw/rtl/triangle_face_normal_unit.sv -----
// Throughput: one request per cycle while busy is low; busy is low except during and right after reset.
// The depth comes from two 32-stage square roots and one divider stage per quotient bit.
// Reset (synchronous) clears all valid bits; requests present during reset are dropped.
// Uses tfn_pkg and tfn_norm.
module triangle_face_normal_unit
   import tfn_pkg::*;
#(
   parameter int COORD_WIDTH      = 32,
   parameter int NORMAL_FRAC_BITS = 14
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic signed [COORD_WIDTH-1:0] req_first_x,
   input  logic signed [COORD_WIDTH-1:0] req_first_y,
   input  logic signed [COORD_WIDTH-1:0] req_first_z,
   input  logic signed [COORD_WIDTH-1:0] req_second_x,
   input  logic signed [COORD_WIDTH-1:0] req_second_y,
   input  logic signed [COORD_WIDTH-1:0] req_second_z,
   input  logic signed [COORD_WIDTH-1:0] req_third_x,
   input  logic signed [COORD_WIDTH-1:0] req_third_y,
   input  logic signed [COORD_WIDTH-1:0] req_third_z,
   output logic                          rsp_valid,
   output logic signed [NORMAL_W-1:0]    rsp_normal_x,
   output logic signed [NORMAL_W-1:0]    rsp_normal_y,
   output logic signed [NORMAL_W-1:0]    rsp_normal_z,
   output logic                          rsp_degenerate
);

   localparam int EW = COORD_WIDTH + 1;
   localparam int NF = NORMAL_FRAC_BITS;

   logic                 busy_ff;
   logic                 accept;
   logic                 e_vld_ff;
   logic signed [EW-1:0] e1_ff [3];
   logic signed [EW-1:0] e2_ff [3];

   norm_stat_type            u_stat, v_stat, n_stat;
   logic signed [UNIT_FRAC+1:0] u_q [3];
   logic signed [UNIT_FRAC+1:0] v_q [3];

   logic                      pa_vld_ff, pa_deg_ff;
   logic signed [CROSS_W-1:0] pa_ff [6];
   logic                      c_vld_ff;
   logic signed [CROSS_W-1:0] c_ff [3];
   logic signed [NF+1:0]      n_q [3];

   logic                      out_vld_ff, out_deg_ff;
   logic signed [NORMAL_W-1:0] out_n_ff [3];
   logic signed [CROSS_W-1:0] n_ext [3];

   // busy covers the cycle after reset so no request is taken while the pipe clears
   always_ff @(posedge clock) begin
      busy_ff <= reset;
   end

   assign busy   = busy_ff;
   assign accept = start & ~busy_ff;

   always_ff @(posedge clock) begin
      if (reset) e_vld_ff <= 1'b0;
      else       e_vld_ff <= accept;
   end

   always_ff @(posedge clock) begin
      e1_ff[0] <= EW'(req_second_x) - EW'(req_first_x);
      e1_ff[1] <= EW'(req_second_y) - EW'(req_first_y);
      e1_ff[2] <= EW'(req_second_z) - EW'(req_first_z);
      e2_ff[0] <= EW'(req_third_x) - EW'(req_first_x);
      e2_ff[1] <= EW'(req_third_y) - EW'(req_first_y);
      e2_ff[2] <= EW'(req_third_z) - EW'(req_first_z);
   end

   tfn_norm #(.IN_W(EW), .FRAC(UNIT_FRAC)) u_norm_e1 (
      .clock    (clock),
      .reset    (reset),
      .in_valid (e_vld_ff),
      .in_c     (e1_ff),
      .out_stat (u_stat),
      .out_q    (u_q)
   );

   tfn_norm #(.IN_W(EW), .FRAC(UNIT_FRAC)) u_norm_e2 (
      .clock    (clock),
      .reset    (reset),
      .in_valid (e_vld_ff),
      .in_c     (e2_ff),
      .out_stat (v_stat),
      .out_q    (v_q)
   );

   // cross product: products, then differences
   always_ff @(posedge clock) begin
      if (reset) begin
         pa_vld_ff <= 1'b0;
         c_vld_ff  <= 1'b0;
      end else begin
         pa_vld_ff <= u_stat.valid;
         c_vld_ff  <= pa_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      pa_ff[0]  <= CROSS_W'(u_q[1]) * CROSS_W'(v_q[2]);
      pa_ff[1]  <= CROSS_W'(u_q[2]) * CROSS_W'(v_q[1]);
      pa_ff[2]  <= CROSS_W'(u_q[2]) * CROSS_W'(v_q[0]);
      pa_ff[3]  <= CROSS_W'(u_q[0]) * CROSS_W'(v_q[2]);
      pa_ff[4]  <= CROSS_W'(u_q[0]) * CROSS_W'(v_q[1]);
      pa_ff[5]  <= CROSS_W'(u_q[1]) * CROSS_W'(v_q[0]);
      pa_deg_ff <= u_stat.zero | v_stat.zero;
      // a zero edge forces a zero cross product, which flags degenerate downstream
      for (int i = 0; i < 3; i++) begin
         c_ff[i] <= pa_deg_ff ? '0 : pa_ff[2*i] - pa_ff[2*i+1];
      end
   end

   tfn_norm #(.IN_W(CROSS_W), .FRAC(NF)) u_norm_cross (
      .clock    (clock),
      .reset    (reset),
      .in_valid (c_vld_ff),
      .in_c     (c_ff),
      .out_stat (n_stat),
      .out_q    (n_q)
   );

   always_comb begin
      for (int i = 0; i < 3; i++) n_ext[i] = CROSS_W'(n_q[i]);
   end

   always_ff @(posedge clock) begin
      if (reset) out_vld_ff <= 1'b0;
      else       out_vld_ff <= n_stat.valid;
   end

   always_ff @(posedge clock) begin
      out_deg_ff <= n_stat.zero;
      for (int i = 0; i < 3; i++) begin
         out_n_ff[i] <= n_stat.zero ? '0 : n_ext[i][NORMAL_W-1:0];
      end
   end

   assign rsp_valid      = out_vld_ff;
   assign rsp_normal_x   = out_n_ff[0];
   assign rsp_normal_y   = out_n_ff[1];
   assign rsp_normal_z   = out_n_ff[2];
   assign rsp_degenerate = out_deg_ff;

endmodule

// ----- hw/rtl/tfn_checker.sv -----
// Port-level assertions for triangle_face_normal_unit, attached by bind.
// Uses tfn_pkg for the latency.
module tfn_checker
   import tfn_pkg::*;
#(
   parameter int COORD_WIDTH      = 32,
   parameter int NORMAL_FRAC_BITS = 14
) (
   input logic                       clock,
   input logic                       reset,
   input logic                       start,
   input logic                       busy,
   input logic                       rsp_valid,
   input logic signed [NORMAL_W-1:0] rsp_normal_x,
   input logic signed [NORMAL_W-1:0] rsp_normal_y,
   input logic signed [NORMAL_W-1:0] rsp_normal_z,
   input logic                       rsp_degenerate
);

   localparam int LAT = top_latency(NORMAL_FRAC_BITS);

   logic accept;
   assign accept = start & ~busy;

   a_req_gets_rsp: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##LAT rsp_valid)
      else $error("request without response");

   a_rsp_has_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, LAT))
      else $error("response without request");

   a_degenerate_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_degenerate) |->
         (rsp_normal_x == '0 && rsp_normal_y == '0 && rsp_normal_z == '0))
      else $error("degenerate response with nonzero normal");

   a_quiet_after_reset: assert property (@(posedge clock)
      $fell(reset) |-> !rsp_valid)
      else $error("response right after reset");

endmodule

bind triangle_face_normal_unit tfn_checker #(
   .COORD_WIDTH      (COORD_WIDTH),
   .NORMAL_FRAC_BITS (NORMAL_FRAC_BITS)
) u_tfn_checker (
   .clock          (clock),
   .reset          (reset),
   .start          (start),
   .busy           (busy),
   .rsp_valid      (rsp_valid),
   .rsp_normal_x   (rsp_normal_x),
   .rsp_normal_y   (rsp_normal_y),
   .rsp_normal_z   (rsp_normal_z),
   .rsp_degenerate (rsp_degenerate)
);
